[hdl/prtc_pkg.sv]
// Package with the types, register bit positions and command codes of the real-time clock.
package prtc_pkg;

    // Control/status register bit positions.
    localparam int CSR_GO        = 0;
    localparam int CSR_OVF_IE    = 6;
    localparam int CSR_OVF       = 7;
    localparam int CSR_ST1       = 8;
    localparam int CSR_ST2       = 9;
    localparam int CSR_OSC       = 10;
    localparam int CSR_DIO       = 11;
    localparam int CSR_FOR       = 12;
    localparam int CSR_CAP_START = 13;
    localparam int CSR_CAP_IE    = 14;
    localparam int CSR_CAP_FLAG  = 15;

    localparam logic [15:0] WR_BITS      = 16'h687F;
    localparam logic [15:0] RD_BITS      = 16'hF8FF;
    localparam logic [15:0] FLAG_BITS    = 16'h9080;
    localparam logic [15:0] RESCHED_BITS = 16'h083E;
    localparam logic [15:0] LANE_HI      = 16'hFF00;
    localparam logic [15:0] LANE_LO      = 16'h00FF;

    // Commands.
    localparam logic [2:0] CMD_READ    = 3'd0;
    localparam logic [2:0] CMD_WORD_WR = 3'd1;
    localparam logic [2:0] CMD_BYTE_WR = 3'd2;
    localparam logic [2:0] CMD_TICK    = 3'd3;
    localparam logic [2:0] CMD_ACK_OVF = 3'd4;
    localparam logic [2:0] CMD_ACK_CAP = 3'd5;

    // Register select.
    localparam logic REG_CSR = 1'b0;
    localparam logic REG_BPR = 1'b1;

    // Modes and rates.
    localparam logic [1:0] MODE_REPEAT    = 2'd1;
    localparam logic [1:0] MODE_EXT_FIRST = 2'd2;
    localparam logic [1:0] MODE_CAP_CLEAR = 2'd3;
    localparam logic [2:0] RATE_LINE      = 3'd7;

    // Configuration registers.
    localparam int               CFG_INDEX_W     = 2;
    localparam int               CFG_DATA_W      = 15;
    localparam logic [1:0]       CFG_LINE_PERIOD = 2'd0;
    localparam logic [1:0]       CFG_VECTOR_BASE = 2'd1;
    localparam logic [14:0]      LINE_PERIOD_RST = 15'd20000;
    localparam logic [8:0]       VECTOR_BASE_RST = 9'd288;
    localparam logic [9:0]       CAP_VEC_OFFSET  = 10'd4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic        reg_sel;
        logic        byte_hi;
        logic [15:0] wdata;
    } item_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        ovf_irq;
        logic        capture_irq;
        logic [9:0]  vector;
    } result_t;

    typedef struct packed {
        logic [15:0] csr;
        logic [15:0] bpr;
        logic [14:0] prescale;
        logic        ovf_req;
        logic        cap_req;
    } state_t;

    // Prescaler period in microseconds for the fixed rates; zero means no tick.
    function automatic logic [14:0] rate_period(input logic [2:0] rate);
        logic [14:0] p;
        case (rate)
            3'd1:    p = 15'd1;
            3'd2:    p = 15'd10;
            3'd3:    p = 15'd100;
            3'd4:    p = 15'd1000;
            3'd5:    p = 15'd10000;
            default: p = 15'd0;
        endcase
        return p;
    endfunction

endpackage

[hdl/prtc_if.sv]
// Handshake channel interfaces for items, results and configuration writes.
interface prtc_item_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic        reg_sel;
    logic        byte_hi;
    logic [15:0] wdata;
    modport source (output valid, cmd, reg_sel, byte_hi, wdata, input ready);
    modport sink   (input valid, cmd, reg_sel, byte_hi, wdata, output ready);
endinterface

interface prtc_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic        ovf_irq;
    logic        capture_irq;
    logic [9:0]  vector;
    modport source (output valid, read_data, ovf_irq, capture_irq, vector, input ready);
    modport sink   (input valid, read_data, ovf_irq, capture_irq, vector, output ready);
endinterface

interface prtc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [prtc_pkg::CFG_INDEX_W-1:0] index;
    logic [prtc_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hdl/prtc_step.sv]
// Next-state and result logic for one word applied to the clock state.
module prtc_step #(
    parameter int CW = 16
) (
    input  prtc_pkg::state_t  st,
    input  logic [CW-1:0]     count,
    input  prtc_pkg::item_t   item,
    input  logic [14:0]       line_period,
    input  logic [8:0]        vector_base,
    output prtc_pkg::state_t  st_next,
    output logic [CW-1:0]     count_next,
    output prtc_pkg::result_t res
);

    // Counter increment; a wrap sets the overflow flags and reloads or stops.
    function automatic void do_advance(inout logic [15:0] c, inout logic [CW-1:0] cnt,
                                       inout logic oreq, inout logic creq,
                                       input logic [15:0] bpr);
        cnt = cnt + CW'(1);
        if (cnt == '0)
        begin
            if (c[prtc_pkg::CSR_OVF])
                c[prtc_pkg::CSR_FOR] = 1'b1;
            c[prtc_pkg::CSR_OVF] = 1'b1;
            if (c[2:1] == prtc_pkg::MODE_REPEAT)
                cnt = CW'(bpr);
            else
                c[prtc_pkg::CSR_GO] = 1'b0;
            oreq = c[prtc_pkg::CSR_OVF] & c[prtc_pkg::CSR_OVF_IE];
            creq = c[prtc_pkg::CSR_CAP_FLAG] & c[prtc_pkg::CSR_CAP_IE];
        end
    endfunction

    always_comb
    begin
        logic [15:0]   c;
        logic [15:0]   old;
        logic [15:0]   bpr;
        logic [CW-1:0] cnt;
        logic [14:0]   psc;
        logic          oreq;
        logic          creq;
        logic [15:0]   rd;
        logic [9:0]    vec;
        logic [15:0]   lane;
        logic [15:0]   val;
        logic [15:0]   merged;
        logic [15:0]   strobe;
        logic [14:0]   period;
        logic [15:0]   psc_inc;

        c       = st.csr;
        old     = st.csr;
        bpr     = st.bpr;
        cnt     = count;
        psc     = st.prescale;
        oreq    = st.ovf_req;
        creq    = st.cap_req;
        rd      = '0;
        vec     = '0;
        lane    = item.byte_hi ? prtc_pkg::LANE_HI : prtc_pkg::LANE_LO;
        val     = item.byte_hi ? {item.wdata[7:0], 8'h00} : {8'h00, item.wdata[7:0]};
        merged  = '0;
        strobe  = '0;
        period  = '0;
        psc_inc = '0;

        case (item.cmd)
            prtc_pkg::CMD_READ:
            begin
                if (item.reg_sel == prtc_pkg::REG_CSR)
                begin
                    rd   = c & prtc_pkg::RD_BITS;
                    c    = c & ~prtc_pkg::FLAG_BITS;
                    oreq = c[prtc_pkg::CSR_OVF] & c[prtc_pkg::CSR_OVF_IE];
                    creq = c[prtc_pkg::CSR_CAP_FLAG] & c[prtc_pkg::CSR_CAP_IE];
                end
                else
                begin
                    rd = bpr;
                end
            end
            prtc_pkg::CMD_WORD_WR, prtc_pkg::CMD_BYTE_WR:
            begin
                if (item.reg_sel == prtc_pkg::REG_CSR)
                begin
                    if (item.cmd == prtc_pkg::CMD_BYTE_WR)
                    begin
                        merged = (c & ~lane) | val;
                        strobe = val;
                    end
                    else
                    begin
                        merged = item.wdata;
                        strobe = item.wdata;
                    end
                    c = (old & ~prtc_pkg::WR_BITS) | (merged & prtc_pkg::WR_BITS);
                    c = c & ~(strobe & prtc_pkg::FLAG_BITS);
                    // Single-step pulse.
                    if (strobe[prtc_pkg::CSR_ST1] && c[prtc_pkg::CSR_GO])
                    begin
                        do_advance(c, cnt, oreq, creq, bpr);
                        psc = '0;
                    end
                    // Capture pulse: counter into the buffer register.
                    if (strobe[prtc_pkg::CSR_ST2] &&
                        (c[prtc_pkg::CSR_GO] || c[prtc_pkg::CSR_CAP_START]))
                    begin
                        if (c[prtc_pkg::CSR_CAP_FLAG])
                            c[prtc_pkg::CSR_FOR] = 1'b1;
                        bpr = 16'(cnt);
                        c[prtc_pkg::CSR_CAP_FLAG] = 1'b1;
                        if (c[2:1] == prtc_pkg::MODE_CAP_CLEAR)
                            cnt = '0;
                        if (c[prtc_pkg::CSR_CAP_START])
                        begin
                            c[prtc_pkg::CSR_GO]        = 1'b1;
                            c[prtc_pkg::CSR_CAP_START] = 1'b0;
                        end
                        oreq = c[prtc_pkg::CSR_OVF] & c[prtc_pkg::CSR_OVF_IE];
                        creq = c[prtc_pkg::CSR_CAP_FLAG] & c[prtc_pkg::CSR_CAP_IE];
                        psc  = '0;
                    end
                    // Oscillator pulse acts as a step unless the DIO bit is set.
                    if (strobe[prtc_pkg::CSR_OSC] && !c[prtc_pkg::CSR_DIO] &&
                        c[prtc_pkg::CSR_GO])
                    begin
                        do_advance(c, cnt, oreq, creq, bpr);
                        psc = '0;
                    end
                    if (!old[prtc_pkg::CSR_GO] && c[prtc_pkg::CSR_GO])
                    begin
                        if (c[2:1] >= prtc_pkg::MODE_EXT_FIRST)
                            cnt = '0;
                        else
                            cnt = CW'(bpr);
                    end
                    if (!c[prtc_pkg::CSR_GO] || ((old ^ c) & prtc_pkg::RESCHED_BITS) != '0)
                        psc = '0;
                    oreq = c[prtc_pkg::CSR_OVF] & c[prtc_pkg::CSR_OVF_IE];
                    creq = c[prtc_pkg::CSR_CAP_FLAG] & c[prtc_pkg::CSR_CAP_IE];
                end
                else
                begin
                    bpr = (item.cmd == prtc_pkg::CMD_BYTE_WR) ? val : item.wdata;
                    if (!c[prtc_pkg::CSR_GO] && c[2:1] < prtc_pkg::MODE_EXT_FIRST)
                        cnt = CW'(bpr);
                    if (c[prtc_pkg::CSR_GO])
                        psc = '0;
                end
            end
            prtc_pkg::CMD_TICK:
            begin
                if (!c[prtc_pkg::CSR_GO])
                    period = '0;
                else if (c[5:3] == prtc_pkg::RATE_LINE)
                    period = line_period;
                else if (c[prtc_pkg::CSR_DIO])
                    period = '0;
                else
                    period = prtc_pkg::rate_period(c[5:3]);
                if (period != '0)
                begin
                    psc_inc = {1'b0, psc} + 16'd1;
                    if (psc_inc >= {1'b0, period})
                    begin
                        psc = '0;
                        do_advance(c, cnt, oreq, creq, bpr);
                    end
                    else
                    begin
                        psc = psc_inc[14:0];
                    end
                end
            end
            prtc_pkg::CMD_ACK_OVF:
            begin
                if (c[prtc_pkg::CSR_OVF] && c[prtc_pkg::CSR_OVF_IE])
                begin
                    oreq = 1'b0;
                    vec  = {1'b0, vector_base};
                end
            end
            prtc_pkg::CMD_ACK_CAP:
            begin
                if (c[prtc_pkg::CSR_CAP_FLAG] && c[prtc_pkg::CSR_CAP_IE])
                begin
                    creq = 1'b0;
                    vec  = {1'b0, vector_base} + prtc_pkg::CAP_VEC_OFFSET;
                end
            end
            default:
            begin
            end
        endcase

        st_next.csr      = c;
        st_next.bpr      = bpr;
        st_next.prescale = psc;
        st_next.ovf_req  = oreq;
        st_next.cap_req  = creq;
        count_next       = cnt;
        res.read_data    = rd;
        res.ovf_irq      = oreq;
        res.capture_irq  = creq;
        res.vector       = vec;
    end

endmodule

[hdl/programmable_realtime_clock_unit.sv]
// Top level of the programmable real-time clock: input register, step logic, result register.
// Flow: an accepted word waits in the input register until the step logic applies it and
// loads its result word into the result register; a result not yet taken holds it there.
// Throughput: one word per cycle while the consumer takes results, as the step logic is combinational.
// Reset: rst_n clears all clock state, the prescaler and both request lines; the line period
// comes up as 20000 us and the vector base as 288. Configuration writes take effect at once.
module programmable_realtime_clock_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    prtc_item_if.sink            item,
    prtc_result_if.source        result,
    prtc_cfg_if.sink             cfg
);

    // Input register: holds one accepted word until the step logic applies it.
    logic              in_valid_reg;
    logic              in_valid_next;
    prtc_pkg::item_t   item_reg;

    // Result register: holds the result word until the consumer takes it.
    logic              out_valid_reg;
    logic              out_valid_next;
    prtc_pkg::result_t res_reg;

    // Architectural state of the clock.
    prtc_pkg::state_t       st_reg;
    prtc_pkg::state_t       st_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;

    // Configuration registers.
    logic [14:0] line_period_reg;
    logic [14:0] line_period_next;
    logic [8:0]  vector_base_reg;
    logic [8:0]  vector_base_next;

    prtc_pkg::state_t       step_st;
    logic [COUNT_WIDTH-1:0] step_count;
    prtc_pkg::result_t      step_res;

    logic item_take;
    logic step_fire;
    logic cfg_wr;

    // A word is applied when one is waiting and the result register is free or draining.
    // Input readiness follows that, so the input register refills in the same cycle.
    assign step_fire   = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready  = !in_valid_reg || step_fire;
    assign item_take   = item.valid && item.ready;
    assign cfg.ready   = 1'b1;
    assign cfg_wr      = cfg.valid;

    prtc_step #(
        .CW (COUNT_WIDTH)
    ) u_step (
        .st          (st_reg),
        .count       (count_reg),
        .item        (item_reg),
        .line_period (line_period_reg),
        .vector_base (vector_base_reg),
        .st_next     (step_st),
        .count_next  (step_count),
        .res         (step_res)
    );

    always_comb
    begin
        in_valid_next    = item_take ? 1'b1 : (step_fire ? 1'b0 : in_valid_reg);
        out_valid_next   = step_fire ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);
        st_next          = step_fire ? step_st : st_reg;
        count_next       = step_fire ? step_count : count_reg;
        line_period_next = line_period_reg;
        vector_base_next = vector_base_reg;
        // Writes must come only while no word is in flight, so they never meet a step; the block does not enforce this.
        if (cfg_wr)
        begin
            case (cfg.index)
                prtc_pkg::CFG_LINE_PERIOD:
                begin
                    line_period_next = cfg.data;
                    // A new line period reschedules the prescaler when it is in use.
                    if (st_reg.csr[5:3] == prtc_pkg::RATE_LINE)
                        st_next.prescale = '0;
                end
                prtc_pkg::CFG_VECTOR_BASE:
                begin
                    vector_base_next = cfg.data[8:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            st_reg          <= '0;
            count_reg       <= '0;
            line_period_reg <= prtc_pkg::LINE_PERIOD_RST;
            vector_base_reg <= prtc_pkg::VECTOR_BASE_RST;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            st_reg          <= st_next;
            count_reg       <= count_next;
            line_period_reg <= line_period_next;
            vector_base_reg <= vector_base_next;
        end
    end

    // Payload registers load without reset.
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_reg.cmd     <= item.cmd;
            item_reg.reg_sel <= item.reg_sel;
            item_reg.byte_hi <= item.byte_hi;
            item_reg.wdata   <= item.wdata;
        end
        if (step_fire)
            res_reg <= step_res;
    end

    assign result.valid       = out_valid_reg;
    assign result.read_data   = res_reg.read_data;
    assign result.ovf_irq     = res_reg.ovf_irq;
    assign result.capture_irq = res_reg.capture_irq;
    assign result.vector      = res_reg.vector;

endmodule
